@@ rtl/core/rrss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the round-robin stripe splitter.
// No dependencies; every other file of the block imports this package.
package rrss_pkg;

    localparam int OFF_W    = 64;   // byte offsets and lengths
    localparam int HALF_W   = 32;   // half of an offset, for the split product
    localparam int STRIPE_W = 33;   // stripe size, chunk length, displacement
    localparam int SRV_W    = 9;    // server count and server numbers
    localparam int FSRV_W   = 8;    // first server register
    localparam int CNT_W    = 7;    // chunk count per request
    localparam int IDX_W    = 2;    // configuration register index
    localparam int STEP_W   = 7;    // divider step count
    localparam int PROD_W   = HALF_W + STRIPE_W;

    localparam logic [STRIPE_W-1:0] STRIPE_MAX = 33'h1_0000_0000;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SERVER_COUNT = 2'd0,
        REG_STRIPE_BYTES = 2'd1,
        REG_FIRST_SERVER = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    // request to the shared divider
    typedef struct packed {
        logic                start;
        logic [OFF_W-1:0]    dividend;
        logic [STRIPE_W-1:0] divisor;
        logic [STEP_W-1:0]   steps;
    } div_req_t;

    // one classified request, handed from front to back
    typedef struct packed {
        logic [OFF_W-1:0]    cursor;
        logic [OFF_W-1:0]    left;
        logic [OFF_W-1:0]    block;
        logic [STRIPE_W-1:0] disp;
        logic [SRV_W-1:0]    bmod;
        logic [SRV_W-1:0]    srv;
        logic [SRV_W-1:0]    fmod;
        logic [OFF_W-1:0]    base;
    } job_t;

endpackage

@@ rtl/core/rrss_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 33-bit divisor.
// Depends on rrss_pkg.
module rrss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrss_pkg::div_req_t            req,
    output logic                          done,
    output logic [rrss_pkg::OFF_W-1:0]    quot,
    output logic [rrss_pkg::STRIPE_W-1:0] rem
);
    import rrss_pkg::*;

    logic [OFF_W-1:0]    dvd_reg;
    logic [STRIPE_W:0]   rem_reg;
    logic [STRIPE_W-1:0] dsr_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [STRIPE_W:0]   shifted;
    logic [STRIPE_W+1:0] diff;
    logic                ge;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg[STRIPE_W-1:0], dvd_reg[OFF_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dsr_reg};
        ge      = ~diff[STRIPE_W+1];
    end

    // control: start, count steps, flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !run_reg)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: shift in quotient bits
    always_ff @(posedge clk)
    begin
        if (req.start && !run_reg)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[OFF_W-2:0], ge};
            rem_reg <= ge ? diff[STRIPE_W:0] : shifted;
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg[STRIPE_W-1:0];

endmodule

@@ rtl/core/rrss_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests and works out block, displacement, server and
// server base offset on a shared divider. Depends on rrss_pkg and rrss_div.
module rrss_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rrss_pkg::OFF_W-1:0]    request_offset,
    input  logic [rrss_pkg::OFF_W-1:0]    request_length,
    input  logic [rrss_pkg::SRV_W-1:0]    ns,
    input  logic [rrss_pkg::STRIPE_W-1:0] sb,
    input  logic [rrss_pkg::FSRV_W-1:0]   first,
    output logic                          push,
    output rrss_pkg::job_t                push_job,
    input  logic                          q_full
);
    import rrss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_DIV3 = 6'b001000,
        S_MUL  = 6'b010000,
        S_PUSH = 6'b100000
    } fstate_t;

    fstate_t             state_reg, state_next;
    logic [OFF_W-1:0]    off_reg, len_reg, block_reg, round_reg;
    logic [STRIPE_W-1:0] disp_reg;
    logic [SRV_W-1:0]    bmod_reg, fmod_reg, srv_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [HALF_W-1:0]   hi_reg;
    logic [SRV_W:0]      srv_sum;
    div_req_t            dreq;
    logic                div_done;
    logic [OFF_W-1:0]    div_quot;
    logic [STRIPE_W-1:0] div_rem;

    rrss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign srv_sum  = {1'b0, fmod_reg} + {1'b0, bmod_reg};

    // sequence the three divisions, the product and the push
    always_comb
    begin
        state_next    = state_reg;
        dreq.start    = 1'b0;
        dreq.dividend = block_reg;
        dreq.divisor  = {{(STRIPE_W-SRV_W){1'b0}}, ns};
        dreq.steps    = STEP_W'(OFF_W);
        unique case (state_reg)
            S_IDLE:
            begin
                dreq.dividend = request_offset;
                dreq.divisor  = sb;
                if (in_valid && request_length != '0)
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                dreq.dividend = div_quot;
                if (div_done)
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                dreq.dividend = {first, {(OFF_W-FSRV_W){1'b0}}};
                dreq.steps    = STEP_W'(FSRV_W);
                if (div_done)
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV3;
                end
            end
            S_DIV3:
            begin
                if (div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!q_full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // capture request and division results
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            off_reg <= request_offset;
            len_reg <= request_length;
        end
        if (state_reg == S_DIV1 && div_done)
        begin
            block_reg <= div_quot;
            disp_reg  <= div_rem;
        end
        if (state_reg == S_DIV2 && div_done)
        begin
            round_reg <= div_quot;
            bmod_reg  <= div_rem[SRV_W-1:0];
        end
        if (state_reg == S_DIV3 && div_done)
            fmod_reg <= div_rem[SRV_W-1:0];
        // round times stripe size, split into low and high halves of the round, and the server number
        if (state_reg == S_MUL)
        begin
            prod_reg <= round_reg[HALF_W-1:0] * sb;
            hi_reg   <= HALF_W'(round_reg[OFF_W-1:HALF_W] * sb[HALF_W-1:0]);
            srv_reg  <= (srv_sum >= {1'b0, ns}) ? SRV_W'(srv_sum - {1'b0, ns})
                                                : srv_sum[SRV_W-1:0];
        end
    end

    // hand the job to the queue
    assign push            = (state_reg == S_PUSH) && !q_full;
    assign push_job.cursor = off_reg;
    assign push_job.left   = len_reg;
    assign push_job.block  = block_reg;
    assign push_job.disp   = disp_reg;
    assign push_job.bmod   = bmod_reg;
    assign push_job.srv    = srv_reg;
    assign push_job.fmod   = fmod_reg;
    assign push_job.base   = prod_reg[OFF_W-1:0] + {hi_reg, {HALF_W{1'b0}}};

endmodule

@@ rtl/core/rrss_queue.sv @@
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// Depends on rrss_pkg.
module rrss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rrss_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output rrss_pkg::job_t pop_job,
    output logic           empty
);
    import rrss_pkg::*;

    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_job = mem_reg[rd_reg];

    // advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

@@ rtl/core/rrss_back.sv @@
`timescale 1ns / 1ps
// Back end: walks one job chunk by chunk, one chunk per cycle while the output
// is not stalled, into an output register. Depends on rrss_pkg.
module rrss_back #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rrss_pkg::SRV_W-1:0]    ns,
    input  logic [rrss_pkg::STRIPE_W-1:0] sb,
    input  logic                          q_empty,
    input  rrss_pkg::job_t                q_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    server_index,
    output logic [rrss_pkg::STRIPE_W-1:0] chunk_length,
    output logic [rrss_pkg::OFF_W-1:0]    server_offset,
    output logic [rrss_pkg::OFF_W-1:0]    block_number,
    output logic                          last_chunk,
    output logic                          truncated
);
    import rrss_pkg::*;

    logic                busy_reg, ov_reg;
    logic [OFF_W-1:0]    cursor_reg, left_reg, block_reg, base_reg;
    logic [STRIPE_W-1:0] disp_reg;
    logic [SRV_W-1:0]    bmod_reg, srv_reg, fmod_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [7:0]          o_srv_reg;
    logic [STRIPE_W-1:0] o_len_reg;
    logic [OFF_W-1:0]    o_off_reg, o_blk_reg;
    logic                o_last_reg, o_trunc_reg;

    logic [STRIPE_W-1:0] room, len;
    logic [OFF_W-1:0]    left_after;
    logic [OFF_W:0]      sum;
    logic [CNT_W-1:0]    cnt_inc;
    logic                hit_max, last, trunc, emit;
    logic                bwrap, swrap;

    // size this chunk and decide whether it ends the job
    always_comb
    begin
        room       = sb - disp_reg;
        len        = (left_reg < {{(OFF_W-STRIPE_W){1'b0}}, room}) ?
                     left_reg[STRIPE_W-1:0] : room;
        left_after = left_reg - {{(OFF_W-STRIPE_W){1'b0}}, len};
        sum        = {1'b0, cursor_reg} + {{(OFF_W+1-STRIPE_W){1'b0}}, len};
        cnt_inc    = cnt_reg + 1'b1;
        hit_max    = (cnt_inc == CNT_W'(MAX_CHUNKS));
        last       = (left_after == '0) || hit_max;
        trunc      = (left_after != '0) && hit_max;
        emit       = busy_reg && (!ov_reg || out_ready);
        bwrap      = (bmod_reg + 1'b1 == ns);
        swrap      = (srv_reg + 1'b1 == ns);
    end

    assign pop = !busy_reg && !q_empty;

    // job walk and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_inc;
                if (last)
                    busy_reg <= 1'b0;
            end
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // chunk state and output word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cursor_reg <= q_job.cursor;
            left_reg   <= q_job.left;
            block_reg  <= q_job.block;
            disp_reg   <= q_job.disp;
            bmod_reg   <= q_job.bmod;
            srv_reg    <= q_job.srv;
            fmod_reg   <= q_job.fmod;
            base_reg   <= q_job.base;
        end
        else if (emit)
        begin
            cursor_reg <= sum[OFF_W-1:0];
            left_reg   <= left_after;
            if (sum[OFF_W])
            begin
                // offset wrapped past the top: restart in block zero
                block_reg <= '0;
                disp_reg  <= sum[STRIPE_W-1:0];
                bmod_reg  <= '0;
                srv_reg   <= fmod_reg;
                base_reg  <= '0;
            end
            else
            begin
                block_reg <= block_reg + 1'b1;
                disp_reg  <= '0;
                bmod_reg  <= bwrap ? '0 : bmod_reg + 1'b1;
                srv_reg   <= swrap ? '0 : srv_reg + 1'b1;
                if (bwrap)
                    base_reg <= base_reg + {{(OFF_W-STRIPE_W){1'b0}}, sb};
            end
        end
        if (emit)
        begin
            o_srv_reg   <= srv_reg[7:0];
            o_len_reg   <= len;
            o_off_reg   <= base_reg + {{(OFF_W-STRIPE_W){1'b0}}, disp_reg};
            o_blk_reg   <= block_reg;
            o_last_reg  <= last;
            o_trunc_reg <= trunc;
        end
    end

    assign out_valid     = ov_reg;
    assign server_index  = o_srv_reg;
    assign chunk_length  = o_len_reg;
    assign server_offset = o_off_reg;
    assign block_number  = o_blk_reg;
    assign last_chunk    = o_last_reg;
    assign truncated     = o_trunc_reg;

    a_srv_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (srv_reg < ns) && (bmod_reg < ns))
        else $error("server number out of range");
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (len != '0))
        else $error("empty chunk emitted");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < CNT_W'(MAX_CHUNKS)))
        else $error("chunk count past limit");
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit && trunc |=> !busy_reg)
        else $error("job continued after truncation");

endmodule

@@ rtl/core/round_robin_stripe_splitter.sv @@
`timescale 1ns / 1ps
// Round-robin stripe splitter: top level with configuration registers.
// Depends on rrss_pkg, rrss_front, rrss_queue, rrss_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: request_offset
//   and request_length. Output channel (out_valid/out_ready) returns one word
//   per chunk: server, length, server offset, block number, last and truncate
//   flags. A zero-length request returns nothing.
//   The front end takes one request at a time and works it out in order:
//   acceptance, offset / stripe size, block / server count and first server
//   mod server count (a divider start plus one divider step per quotient bit
//   each), the product and the push; the single shared divider sets how often
//   a request can be taken. The back end then emits one chunk per cycle while
//   out_ready is high, at most MAX_CHUNKS per request; a two-entry queue lets
//   the next request be classified while chunks of the previous one drain.
//   Configuration (cfg_we, cfg_index, cfg_data) is to be written only while
//   idle (a user rule the block does not enforce); unknown indexes are ignored.
//   Reset clears all control state and loads server count 1, stripe size
//   4 MiB and first server 0.
//   When out_ready is low the output word holds; the back end stalls, then the
//   queue fills, then in_ready stays low.
module round_robin_stripe_splitter #(
    parameter int MAX_SERVERS = 256,
    parameter int MAX_CHUNKS  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rrss_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rrss_pkg::STRIPE_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rrss_pkg::OFF_W-1:0]    request_offset,
    input  logic [rrss_pkg::OFF_W-1:0]    request_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    server_index,
    output logic [rrss_pkg::STRIPE_W-1:0] chunk_length,
    output logic [rrss_pkg::OFF_W-1:0]    server_offset,
    output logic [rrss_pkg::OFF_W-1:0]    block_number,
    output logic                          last_chunk,
    output logic                          truncated
);
    import rrss_pkg::*;

    logic [SRV_W-1:0]    nsrv_reg;
    logic [STRIPE_W-1:0] stripe_reg;
    logic [FSRV_W-1:0]   first_reg;
    logic [SRV_W-1:0]    ns_eff;
    logic [STRIPE_W-1:0] sb_eff;
    logic                push, pop, q_full, q_empty;
    job_t                push_job, pop_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsrv_reg   <= SRV_W'(1);
            stripe_reg <= STRIPE_W'(4194304);
            first_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SERVER_COUNT: nsrv_reg   <= cfg_data[SRV_W-1:0];
                REG_STRIPE_BYTES: stripe_reg <= cfg_data;
                REG_FIRST_SERVER: first_reg  <= cfg_data[FSRV_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp the registers to their working ranges
    always_comb
    begin
        if (nsrv_reg == '0)
            ns_eff = SRV_W'(1);
        else if ({8'b0, nsrv_reg} > 17'(MAX_SERVERS))
            ns_eff = SRV_W'(MAX_SERVERS);
        else
            ns_eff = nsrv_reg;
        if (stripe_reg == '0)
            sb_eff = STRIPE_W'(1);
        else if (stripe_reg > STRIPE_MAX)
            sb_eff = STRIPE_MAX;
        else
            sb_eff = stripe_reg;
    end

    rrss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .request_offset (request_offset),
        .request_length (request_length),
        .ns             (ns_eff),
        .sb             (sb_eff),
        .first          (first_reg),
        .push           (push),
        .push_job       (push_job),
        .q_full         (q_full)
    );

    rrss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    rrss_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ns            (ns_eff),
        .sb            (sb_eff),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .server_index  (server_index),
        .chunk_length  (chunk_length),
        .server_offset (server_offset),
        .block_number  (block_number),
        .last_chunk    (last_chunk),
        .truncated     (truncated)
    );

endmodule
